### rtl/i2c_master_transfer_sequencer_top_assert.svh
// Assertion macros for the I2C transfer sequencer top level.
// Needs clk and rst_n in the scope of each use.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define IMTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/imts_pkg.sv
// Package for the I2C transfer sequencer: item codes, phase type, word structs.
// No dependencies.
package imts_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [1:0] MODE_WRITE      = 2'd0;
    localparam logic [1:0] MODE_READ       = 2'd1;
    localparam logic [1:0] MODE_WRITE_READ = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;
    localparam logic [7:0] TIMEOUT_RESET   = 8'd200;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2,
        PH_RADDR = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] mode;
        logic [7:0] address;
        logic [5:0] write_length;
        logic [7:0] read_length;
        logic [4:0] load_index;
        logic [7:0] load_byte;
        logic       nak;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] tx_byte;
        logic       start_cond;
        logic       repeated_start;
        logic       stop_cond;
        logic       to_receive;
        logic       prepare_nak;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       done_res;
        logic       success;
    } result_t;

endpackage

### rtl/imts_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface imts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/imts_wbuf.sv
// Write byte buffer: one write port, one registered read port, write-first.
// No dependencies.
module imts_wbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/imts_core.sv
// Sequencer core: transfer state, per-word decision and result register.
// Uses imts_pkg, imts_stream_if and imts_wbuf.
module imts_core
    import imts_pkg::*;
#(
    parameter int WRITE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          timeout_ticks,
    imts_stream_if.sink         in_ch,
    imts_stream_if.source       out_ch
);

    localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(WRITE_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [5:0] write_count_reg, write_count_next;
    logic [5:0] write_total_reg, write_total_next;
    logic [7:0] read_count_reg, read_count_next;
    logic [7:0] read_total_reg, read_total_next;
    logic       restart_reg, restart_next;
    logic [7:0] raddr_byte_reg, raddr_byte_next;
    logic       error_reg, error_next;
    logic [7:0] tick_reg, tick_next;

    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    res;

    in_item_t   item;
    logic       accept;
    logic       fin;
    logic       fin_ok;
    logic [5:0] wlen_sat;
    logic [7:0] rc_inc;
    logic [7:0] remain;

    logic          wb_we;
    logic [AW-1:0] wb_waddr;
    logic [AW-1:0] wb_raddr;
    logic [7:0]    wb_rdata;

    assign item         = in_ch.data;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign wlen_sat = ({3'b000, item.write_length} > DEPTH9) ? 6'(WRITE_DEPTH)
                                                              : item.write_length;
    assign rc_inc   = read_count_reg + 8'd1;
    assign remain   = read_total_reg - rc_inc;
    assign wb_waddr = AW'(item.load_index);
    assign wb_raddr = ({3'b000, write_count_next} < DEPTH9) ? AW'(write_count_next)
                                                             : '0;

    always_comb
    begin
        phase_next       = phase_reg;
        write_count_next = write_count_reg;
        write_total_next = write_total_reg;
        read_count_next  = read_count_reg;
        read_total_next  = read_total_reg;
        restart_next     = restart_reg;
        raddr_byte_next  = raddr_byte_reg;
        error_next       = error_reg;
        tick_next        = tick_reg;
        res              = '0;
        wb_we            = 1'b0;
        fin              = 1'b0;
        fin_ok           = 1'b0;

        if (accept)
        begin
            case (item.kind)
                KIND_LOAD:
                begin
                    wb_we = ({4'b0000, item.load_index} < DEPTH9);
                end
                KIND_START:
                begin
                    if ((phase_reg == PH_IDLE) && (item.mode != MODE_RESERVED))
                    begin
                        error_next     = 1'b0;
                        tick_next      = 8'd0;
                        restart_next   = 1'b0;
                        res.start_cond = 1'b1;
                        res.send_valid = 1'b1;
                        if (item.mode == MODE_READ)
                        begin
                            read_total_next = item.read_length;
                            read_count_next = 8'd0;
                            phase_next      = PH_RADDR;
                            res.tx_byte     = item.address | ADDR_READ_BIT;
                        end
                        else
                        begin
                            write_total_next = wlen_sat;
                            write_count_next = 6'd0;
                            if (item.mode == MODE_WRITE_READ)
                            begin
                                restart_next    = (item.read_length != 8'd0);
                                read_total_next = item.read_length;
                                read_count_next = 8'd0;
                                raddr_byte_next = item.address | ADDR_READ_BIT;
                            end
                            phase_next  = PH_WRITE;
                            res.tx_byte = item.address & ADDR_WRITE_MASK;
                        end
                    end
                end
                KIND_EVENT:
                begin
                    case (phase_reg)
                        PH_WRITE:
                        begin
                            if (write_count_reg < write_total_reg)
                            begin
                                if (!item.nak)
                                begin
                                    write_count_next = write_count_reg + 6'd1;
                                    res.send_valid   = 1'b1;
                                    res.tx_byte      = wb_rdata;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            else if (!restart_reg)
                            begin
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end
                            else
                            begin
                                res.repeated_start = 1'b1;
                                res.send_valid     = 1'b1;
                                res.tx_byte        = raddr_byte_reg;
                                restart_next       = 1'b0;
                                phase_next         = PH_RADDR;
                            end
                        end
                        PH_RADDR:
                        begin
                            res.to_receive = 1'b1;
                            if (!item.nak)
                            begin
                                phase_next = PH_READ;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        PH_READ:
                        begin
                            if (read_count_reg < read_total_reg)
                            begin
                                res.store_valid = 1'b1;
                                res.store_index = read_count_reg;
                                res.store_byte  = item.rx_byte;
                                read_count_next = rc_inc;
                                if (remain == 8'd1)
                                begin
                                    fin    = 1'b1;
                                    fin_ok = 1'b1;
                                end
                                res.prepare_nak = (remain <= 8'd2);
                            end
                            else
                            begin
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (tick_reg >= timeout_ticks)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            tick_next = tick_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase

            if (fin)
            begin
                error_next    = error_reg || !fin_ok;
                res.stop_cond = 1'b1;
                res.done_res  = 1'b1;
                res.success   = !error_next;
                phase_next    = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            write_count_reg <= '0;
            write_total_reg <= '0;
            read_count_reg  <= '0;
            read_total_reg  <= '0;
            restart_reg     <= 1'b0;
            raddr_byte_reg  <= '0;
            error_reg       <= 1'b0;
            tick_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            write_count_reg <= write_count_next;
            write_total_reg <= write_total_next;
            read_count_reg  <= read_count_next;
            read_total_reg  <= read_total_next;
            restart_reg     <= restart_next;
            raddr_byte_reg  <= raddr_byte_next;
            error_reg       <= error_next;
            tick_reg        <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

    imts_wbuf #(
        .DEPTH (WRITE_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wb_waddr),
        .wdata (item.load_byte),
        .raddr (wb_raddr),
        .rdata (wb_rdata)
    );

endmodule

### rtl/i2c_master_transfer_sequencer_top.sv
// channel     dir  word         handshake
// in_ch       in   in_item_t    valid/ready
// out_ch      out  result_t     valid/ready
// cfg         in   timeout      cfg_wr_en, no read-back
// One word in per cycle unless out_ch stalls; its result word is in the output
// register in the cycle after acceptance. The decision is a single pass of logic
// between the accepted word and the result register; the write buffer read is
// prefetched. in_ch.ready drops only while an unaccepted result is held at out_ch.
// Reset clears state and the output valid; the write buffer is not cleared.
// Top level of the I2C transfer sequencer: timeout register and core.
// Uses imts_pkg, imts_stream_if, imts_core and the assertion macro header.
`include "i2c_master_transfer_sequencer_top_assert.svh"

module i2c_master_transfer_sequencer_top
    import imts_pkg::*;
#(
    parameter int WRITE_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    imts_stream_if.sink   in_ch,
    imts_stream_if.source out_ch
);

    logic [7:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    imts_core #(
        .WRITE_DEPTH (WRITE_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .in_ch         (in_ch),
        .out_ch        (out_ch)
    );

    `IMTS_ASSERT_NEXT(a_accept_gives_result, in_ch.valid && in_ch.ready, out_ch.valid, "accepted word without result")
    `IMTS_ASSERT_IMPL(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken while result stalled")
    `IMTS_ASSERT_IMPL(a_done_stops, out_ch.valid && out_ch.data.done_res, out_ch.data.stop_cond && !out_ch.data.send_valid, "done without stop")
    `IMTS_ASSERT_IMPL(a_success_with_done, out_ch.valid && out_ch.data.success, out_ch.data.done_res, "success outside done")

endmodule
